// ===== hw/rtl/pid_antiwindup_step_assert.svh =====
// Assertion macros for the PID step block
`ifndef PID_ANTIWINDUP_STEP_ASSERT_SVH
`define PID_ANTIWINDUP_STEP_ASSERT_SVH

// same-cycle implication
`define PAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pas_pkg.sv =====
// Types and constants of the PID step block
package pas_pkg;

  localparam int unsigned SigW   = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned DtW    = 24;
  localparam int unsigned IntegW = 48;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_PROP     = 3'd0,
    CFG_GAIN_INTEG    = 3'd1,
    CFG_GAIN_DERIV    = 3'd2,
    CFG_DRIVE_FLOOR   = 3'd3,
    CFG_DRIVE_CEILING = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SigW-1:0] setpoint;
    logic signed [SigW-1:0] measured;
    logic [DtW-1:0]         step_time;
    logic                   restart;
  } in_t;

  typedef struct packed {
    logic signed [SigW-1:0] drive;
    logic signed [SigW-1:0] error_now;
    logic                   integral_frozen;
    logic                   saturated;
  } out_t;

endpackage

// ===== hw/rtl/pid_antiwindup_step.sv =====
// PID step with conditional-integration anti-windup, bit-serial arithmetic
//
//   channel  | signals                            | direction
//   ---------+------------------------------------+----------
//   input    | in_valid_i in_stall_o in_data_i    | in
//   result   | out_valid_o out_stall_i out_data_o | out
//   config   | cfg_we_i cfg_idx_i cfg_data_i      | in
//
// One transaction at a time. A restart goes straight to the result. Otherwise the
// error is formed, the radix-2 divider runs when step_time is nonzero, the products
// run one after another on the shared shift-add multiplier (2 products with
// integration off, 7 with it on), and a final step sets drive and integral.
// Reset clears control, state and limits to their reset values.
// A stalled result waits in the output register; the next input is taken meanwhile.
module pid_antiwindup_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pas_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pas_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pas_pkg::SigW-1:0]      cfg_data_i
);

  localparam int unsigned TermW = 63;
  localparam int unsigned ProdW = 64;
  localparam int unsigned NumW  = 49;
  localparam logic signed [ProdW-1:0] TermLim = 64'sh2000_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_DLOAD, S_DIV, S_MLOAD, S_MUL, S_MSTORE, S_FIN, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_KP_E, OP_KD_D, OP_E_DT, OP_KI_HI, OP_KI_LO, OP_KI_CAND_HI, OP_KI_CAND_LO
  } op_e;

  state_e state_q;
  pas_pkg::in_t  in_q;
  pas_pkg::out_t res_q, out_q;
  logic out_valid_q;

  logic signed [31:0] kp_q, ki_q, kd_q, floor_q, ceil_q;
  logic signed [31:0] last_err_q, e_q, d_q;
  logic signed [47:0] integ_q, cand_q, tp_q, td_q;
  logic signed [TermW-1:0] hi_q, ti_cur_q, ti_cand_q;
  logic integ_en_q;
  op_e op_q;
  logic [5:0] cnt_q;

  logic [31:0] mul_a_q, mul_b_q;
  logic [ProdW-1:0] mul_acc_q;
  logic mul_neg_q;

  logic [NumW-1:0] div_n_q;
  logic [23:0] div_r_q;
  logic div_neg_q;

  function automatic logic signed [TermW-1:0] sat_term(logic signed [ProdW-1:0] x);
    logic signed [ProdW-1:0] y;
    y = (x > TermLim) ? TermLim : ((x < -TermLim) ? -TermLim : x);
    return y[TermW-1:0];
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  // operand selection for the shared multiplier
  logic signed [31:0] opa, opb;
  always_comb begin
    case (op_q)
      OP_KP_E:       begin opa = kp_q; opb = e_q; end
      OP_KD_D:       begin opa = kd_q; opb = d_q; end
      OP_E_DT:       begin opa = e_q;  opb = {8'b0, in_q.step_time}; end
      OP_KI_HI:      begin opa = ki_q; opb = integ_q[47:16]; end
      OP_KI_LO:      begin opa = ki_q; opb = {16'b0, integ_q[15:0]}; end
      OP_KI_CAND_HI: begin opa = ki_q; opb = cand_q[47:16]; end
      OP_KI_CAND_LO: begin opa = ki_q; opb = {16'b0, cand_q[15:0]}; end
      default:       begin opa = '0;   opb = '0; end
    endcase
  end

  logic [32:0] mul_sum;
  logic signed [ProdW-1:0] prod;
  logic signed [47:0] prod_fl;
  logic signed [48:0] cand_sum;
  logic signed [ProdW-1:0] term_sum;
  assign mul_sum  = {1'b0, mul_acc_q[63:32]} + (mul_b_q[0] ? {1'b0, mul_a_q} : 33'd0);
  assign prod     = mul_neg_q ? -$signed(mul_acc_q) : $signed(mul_acc_q);
  assign prod_fl  = prod[63:16];
  assign cand_sum = {integ_q[47], integ_q} + {prod_fl[47], prod_fl};
  assign term_sum = {{(ProdW-TermW){hi_q[TermW-1]}}, hi_q}
                  + {{(ProdW-48){prod_fl[47]}}, prod_fl};

  logic [24:0] div_try;
  logic div_ge;
  logic [NumW-1:0] div_q;
  assign div_try = {div_r_q, div_n_q[NumW-1]};
  assign div_ge  = div_try >= {1'b0, in_q.step_time};
  assign div_q   = {div_n_q[NumW-2:0], div_ge};

  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic signed [32:0] err_full;
  assign diff     = {e_q[31], e_q} - {last_err_q[31], last_err_q};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign err_full = {in_q.setpoint[31], in_q.setpoint} - {in_q.measured[31], in_q.measured};

  logic signed [ProdW-1:0] raw_cur, raw_cand, cl_cur, cl_cand, ceil_x, floor_x;
  assign ceil_x  = {{32{ceil_q[31]}}, ceil_q};
  assign floor_x = {{32{floor_q[31]}}, floor_q};
  assign raw_cur = {{16{tp_q[47]}}, tp_q} + {{16{td_q[47]}}, td_q}
                 + (integ_en_q ? {ti_cur_q[TermW-1], ti_cur_q} : 64'sd0);
  assign raw_cand = {{16{tp_q[47]}}, tp_q} + {{16{td_q[47]}}, td_q}
                  + {ti_cand_q[TermW-1], ti_cand_q};
  assign cl_cur  = (raw_cur > ceil_x) ? ceil_x : ((raw_cur < floor_x) ? floor_x : raw_cur);
  assign cl_cand = (raw_cand > ceil_x) ? ceil_x : ((raw_cand < floor_x) ? floor_x : raw_cand);

  logic accept;
  assign accept = (raw_cur == cl_cur) || (cl_cur >= ceil_x && e_q < 0)
               || (cl_cur <= floor_x && e_q > 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      floor_q     <= 32'sh8000_0000;
      ceil_q      <= 32'sh7fff_ffff;
      last_err_q  <= '0;
      integ_q     <= '0;
      op_q        <= OP_KP_E;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pas_pkg::CFG_GAIN_PROP:     kp_q    <= cfg_data_i;
          pas_pkg::CFG_GAIN_INTEG:    ki_q    <= cfg_data_i;
          pas_pkg::CFG_GAIN_DERIV:    kd_q    <= cfg_data_i;
          pas_pkg::CFG_DRIVE_FLOOR:   floor_q <= cfg_data_i;
          pas_pkg::CFG_DRIVE_CEILING: ceil_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q <= in_data_i;
            if (in_data_i.restart) begin
              last_err_q <= '0;
              integ_q    <= '0;
              res_q      <= '0;
              state_q    <= S_DONE;
            end else begin
              state_q <= S_ERR;
            end
          end
        end
        S_ERR: begin
          if (err_full[32] != err_full[31])
            e_q <= err_full[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          else
            e_q <= err_full[31:0];
          integ_en_q <= (ki_q != 0) && (in_q.step_time != 0);
          state_q    <= S_DLOAD;
        end
        S_DLOAD: begin
          last_err_q <= e_q;
          op_q       <= OP_KP_E;
          if (in_q.step_time == 0) begin
            d_q     <= '0;
            state_q <= S_MLOAD;
          end else begin
            div_n_q   <= {diff_mag, 16'b0};
            div_r_q   <= '0;
            div_neg_q <= diff[32];
            cnt_q     <= 6'(NumW - 1);
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          div_r_q <= div_ge ? 24'(div_try - {1'b0, in_q.step_time}) : 24'(div_try);
          div_n_q <= div_q;
          cnt_q   <= cnt_q - 6'd1;
          if (cnt_q == 0) begin
            if (div_neg_q)
              d_q <= (div_q > 49'h0_8000_0000) ? 32'sh8000_0000 : 32'(-div_q);
            else
              d_q <= (div_q > 49'h0_7fff_ffff) ? 32'sh7fff_ffff : div_q[31:0];
            state_q <= S_MLOAD;
          end
        end
        S_MLOAD: begin
          mul_a_q   <= mag32(opa);
          mul_b_q   <= mag32(opb);
          mul_neg_q <= opa[31] ^ opb[31];
          mul_acc_q <= '0;
          cnt_q     <= 6'd31;
          state_q   <= S_MUL;
        end
        S_MUL: begin
          mul_acc_q <= {mul_sum, mul_acc_q[31:1]};
          mul_b_q   <= {1'b0, mul_b_q[31:1]};
          cnt_q     <= cnt_q - 6'd1;
          if (cnt_q == 0) state_q <= S_MSTORE;
        end
        S_MSTORE: begin
          state_q <= S_MLOAD;
          case (op_q)
            OP_KP_E: begin tp_q <= prod_fl; op_q <= OP_KD_D; end
            OP_KD_D: begin
              td_q <= prod_fl;
              op_q <= OP_E_DT;
              if (!integ_en_q) state_q <= S_FIN;
            end
            OP_E_DT: begin
              if (cand_sum[48] != cand_sum[47])
                cand_q <= cand_sum[48] ? 48'sh8000_0000_0000 : 48'sh7fff_ffff_ffff;
              else
                cand_q <= cand_sum[47:0];
              op_q <= OP_KI_HI;
            end
            OP_KI_HI: begin hi_q <= sat_term(prod); op_q <= OP_KI_LO; end
            OP_KI_LO: begin ti_cur_q <= sat_term(term_sum); op_q <= OP_KI_CAND_HI; end
            OP_KI_CAND_HI: begin hi_q <= sat_term(prod); op_q <= OP_KI_CAND_LO; end
            OP_KI_CAND_LO: begin ti_cand_q <= sat_term(term_sum); state_q <= S_FIN; end
            default: state_q <= S_FIN;
          endcase
        end
        S_FIN: begin
          res_q.error_now <= e_q;
          if (!integ_en_q) begin
            integ_q               <= '0;
            res_q.drive           <= cl_cur[31:0];
            res_q.saturated       <= raw_cur != cl_cur;
            res_q.integral_frozen <= 1'b0;
          end else if (accept) begin
            integ_q               <= cand_q;
            res_q.drive           <= cl_cand[31:0];
            res_q.saturated       <= raw_cand != cl_cand;
            res_q.integral_frozen <= 1'b0;
          end else begin
            res_q.drive           <= cl_cur[31:0];
            res_q.saturated       <= raw_cur != cl_cur;
            res_q.integral_frozen <= 1'b1;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/pas_checker.sv =====
// Port-level checks for the PID step block, bound to the top level
`include "pid_antiwindup_step_assert.svh"

module pas_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input pas_pkg::out_t out_data_o
);

  `PAS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `PAS_ASSERT_NOW(a_frozen_sat, out_valid_o && out_data_o.integral_frozen, out_data_o.saturated, "frozen integral without clamp")
  `PAS_ASSERT_NEXT(a_busy, in_valid_i && !in_stall_o, in_stall_o, "second transaction taken while busy")

endmodule

bind pid_antiwindup_step pas_checker u_pas_checker (.*);

// ===== dv/tb_pid_antiwindup_step.sv =====
// Testbench for the PID step block: random and directed stimulus checked against a predictor
`timescale 1ns / 1ps

module tb_pid_antiwindup_step;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int HoldCycles = 3000;
  localparam longint TermLim = 64'sd1 <<< 61;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pas_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pas_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [pas_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [pas_pkg::SigW-1:0] cfg_data_i = '0;

  pid_antiwindup_step dut (.*);

  always #2 clk_i = ~clk_i;

  pas_pkg::in_t pending_q[$];
  pas_pkg::out_t expected_q[$];
  int n_fail = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  bit stim_done = 1'b0;
  bit in_acc = 1'b0;

  longint k_prop, k_integ, k_deriv, lim_lo, lim_hi, prev_err, integ_acc;

  function automatic longint sat_to(longint x, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic longint flr(longint x);
    return x >>> pas_pkg::FracW;
  endfunction

  function automatic longint clip_term(longint x);
    return x > TermLim ? TermLim : (x < -TermLim ? -TermLim : x);
  endfunction

  function automatic longint sum_terms(longint e, longint integ, longint d);
    longint hpart, lpart, it;
    hpart = flr(integ);
    lpart = integ - (hpart <<< pas_pkg::FracW);
    it = clip_term(clip_term(k_integ * hpart) + flr(k_integ * lpart));
    return clip_term(flr(k_prop * e)) + it + clip_term(flr(k_deriv * d));
  endfunction

  function automatic longint clamp_out(longint v);
    if (v > lim_hi) return lim_hi;
    if (v < lim_lo) return lim_lo;
    return v;
  endfunction

  function automatic pas_pkg::out_t predict_step(pas_pkg::in_t it);
    pas_pkg::out_t r;
    longint e, d, dt, raw, cur_raw, cur_cl, cand, cand_raw, drv;
    bit frozen, sat, ok;
    r = '0;
    frozen = 1'b0;
    d = 0;
    if (it.restart) begin
      prev_err = 0;
      integ_acc = 0;
      return r;
    end
    dt = longint'(it.step_time);
    e = sat_to(longint'(it.setpoint) - longint'(it.measured), pas_pkg::SigW);
    if (dt > 0) d = sat_to(((e - prev_err) <<< pas_pkg::FracW) / dt, pas_pkg::SigW);
    prev_err = e;
    if (k_integ == 0 || dt == 0) begin
      integ_acc = 0;
      raw = sum_terms(e, 0, d);
      drv = clamp_out(raw);
      sat = raw != drv;
    end else begin
      cand = sat_to(integ_acc + flr(e * dt), pas_pkg::IntegW);
      cur_raw = sum_terms(e, integ_acc, d);
      cur_cl = clamp_out(cur_raw);
      ok = (cur_raw == cur_cl) || (cur_cl >= lim_hi && e < 0) || (cur_cl <= lim_lo && e > 0);
      if (ok) begin
        cand_raw = sum_terms(e, cand, d);
        drv = clamp_out(cand_raw);
        sat = cand_raw != drv;
        integ_acc = cand;
      end else begin
        drv = cur_cl;
        sat = cur_raw != cur_cl;
        frozen = 1'b1;
      end
    end
    r.drive = drv[31:0];
    r.error_now = e[31:0];
    r.integral_frozen = frozen;
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_sig();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 1 << 20)) - 32'h00080000;
      default: return $urandom();
    endcase
  endfunction

  function automatic pas_pkg::in_t rand_item();
    pas_pkg::in_t it;
    it.setpoint = rand_sig();
    it.measured = ($urandom_range(0, 3) == 0) ? rand_sig() :
                  it.setpoint - 32'($urandom_range(0, 1 << 18)) + 32'h00020000;
    case ($urandom_range(0, 5))
      0: it.step_time = '0;
      1: it.step_time = 24'hffffff;
      2: it.step_time = 24'($urandom_range(1, 1 << 16));
      default: it.step_time = 24'($urandom());
    endcase
    it.restart = ($urandom_range(0, 29) == 0);
    return it;
  endfunction

  // driver
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_q[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= 0;
        end else if (burst_left == 1) begin
          burst_left <= 0;
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // take the accepted transaction and predict its result
  always @(posedge clk_i) begin
    in_acc <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_q.push_back(predict_step(in_data_i));
      void'(pending_q.pop_front());
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 97;
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_phase < 40) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 2) == 0);
  end

  // monitor
  always @(posedge clk_i) begin
    pas_pkg::out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: %h", out_data_o);
        n_fail++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data_o.drive !== exp_r.drive) begin
          $error("drive: expected %h, got %h", exp_r.drive, out_data_o.drive);
          n_fail++;
        end
        if (out_data_o.error_now !== exp_r.error_now) begin
          $error("error_now: expected %h, got %h", exp_r.error_now, out_data_o.error_now);
          n_fail++;
        end
        if (out_data_o.integral_frozen !== exp_r.integral_frozen) begin
          $error("integral_frozen: expected %b, got %b", exp_r.integral_frozen,
                 out_data_o.integral_frozen);
          n_fail++;
        end
        if (out_data_o.saturated !== exp_r.saturated) begin
          $error("saturated: expected %b, got %b", exp_r.saturated, out_data_o.saturated);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || stim_done
        || hold_left > 0)
      idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(pas_pkg::cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pas_pkg::CFG_GAIN_PROP: k_prop = longint'(signed'(val));
      pas_pkg::CFG_GAIN_INTEG: k_integ = longint'(signed'(val));
      pas_pkg::CFG_GAIN_DERIV: k_deriv = longint'(signed'(val));
      pas_pkg::CFG_DRIVE_FLOOR: lim_lo = longint'(signed'(val));
      pas_pkg::CFG_DRIVE_CEILING: lim_hi = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic send(logic [31:0] sp, logic [31:0] ms, logic [23:0] dt, logic rs);
    pas_pkg::in_t it;
    it.setpoint = sp;
    it.measured = ms;
    it.step_time = dt;
    it.restart = rs;
    pending_q.push_back(it);
  endtask

  task automatic run_random(int n);
    repeat (n) pending_q.push_back(rand_item());
  endtask

  initial begin
    k_prop = 0; k_integ = 0; k_deriv = 0;
    lim_lo = -(64'sd1 <<< 31); lim_hi = (64'sd1 <<< 31) - 1;
    prev_err = 0; integ_acc = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset gains: drive zero
    send(32'h00010000, 32'h0, 24'h010000, 1'b0);
    drain();
    write_reg(pas_pkg::CFG_GAIN_PROP, 32'h00010000);
    write_reg(pas_pkg::CFG_GAIN_INTEG, 32'h00008000);
    write_reg(pas_pkg::CFG_GAIN_DERIV, 32'h00000800);
    write_reg(pas_pkg::CFG_DRIVE_FLOOR, 32'hfff00000);
    write_reg(pas_pkg::CFG_DRIVE_CEILING, 32'h00100000);
    send(32'h7fffffff, 32'h80000000, 24'h010000, 1'b0);
    send(32'h80000000, 32'h7fffffff, 24'hffffff, 1'b0);
    send(32'h7fffffff, 32'h80000000, 24'h000001, 1'b0);
    send(32'h00050000, 32'h0, 24'h010000, 1'b0);
    send(32'h00050000, 32'h0, 24'h010000, 1'b0);
    send(32'h00050000, 32'h0, 24'h010000, 1'b0);
    send(32'hfff00000, 32'h0, 24'h010000, 1'b0);
    send(32'h00010000, 32'h00010000, 24'h0, 1'b0);
    send(32'h12345678, 32'h0, 24'h000100, 1'b1);
    send(32'h0, 32'h0, 24'h0, 1'b0);
    drain();
    // crossed limits
    write_reg(pas_pkg::CFG_DRIVE_FLOOR, 32'h00010000);
    write_reg(pas_pkg::CFG_DRIVE_CEILING, 32'hffff0000);
    send(32'h00020000, 32'h0, 24'h010000, 1'b0);
    send(32'h0, 32'h0, 24'h010000, 1'b0);
    send(32'hfffe0000, 32'h0, 24'h010000, 1'b0);
    drain();

    // extreme gains, full limits
    write_reg(pas_pkg::CFG_GAIN_PROP, 32'h7fffffff);
    write_reg(pas_pkg::CFG_GAIN_INTEG, 32'h80000000);
    write_reg(pas_pkg::CFG_GAIN_DERIV, 32'h7fffffff);
    write_reg(pas_pkg::CFG_DRIVE_FLOOR, 32'h80000000);
    write_reg(pas_pkg::CFG_DRIVE_CEILING, 32'h7fffffff);
    run_random(150);
    // long receiver hold-off while items keep coming
    for (int k = 0; k < 20; k++) send($urandom(), $urandom(), 24'($urandom()), 1'b0);
    while (pending_q.size() > 18) @(posedge clk_i);
    hold_req = 1'b1;
    wait (hold_seen && hold_left == 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(pas_pkg::CFG_GAIN_PROP,
                (ph == 2) ? 32'h80000000 : 32'($urandom_range(0, 1 << 18)));
      write_reg(pas_pkg::CFG_GAIN_INTEG,
                (ph == 3) ? 32'h0 : $urandom() >> $urandom_range(8, 20));
      write_reg(pas_pkg::CFG_GAIN_DERIV,
                (ph == 4) ? 32'hffffffff : $urandom() >> $urandom_range(10, 24));
      write_reg(pas_pkg::CFG_DRIVE_FLOOR, -32'($urandom_range(1, 1 << 24)));
      write_reg(pas_pkg::CFG_DRIVE_CEILING, 32'($urandom_range(0, 1 << 24)));
      run_random(150);
      drain();
    end

    stim_done = 1'b1;
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
